>>> sv/mwf_pkg.sv
package mwf_pkg;

  localparam int MAX_SIDE = 32;
  localparam int CW       = 5;
  localparam int IW       = 15;
  localparam int VOL      = 32768;
  localparam int DW       = 6;
  localparam int GW       = 8;
  localparam int LEVELS   = 256;
  localparam int LVW      = 8;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_ADD  = 2'd1;
  localparam logic [1:0] ACT_RUN  = 2'd2;
  localparam logic [1:0] ACT_READ = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOMARK = 2'd1;
  localparam logic [1:0] ST_OVF    = 2'd2;

  localparam logic [1:0] REG_X = 2'd0;
  localparam logic [1:0] REG_Y = 2'd1;
  localparam logic [1:0] REG_Z = 2'd2;

  localparam logic [1:0] OFF_MID = 2'd1;
  localparam logic [1:0] OFF_TOP = 2'd2;

  typedef struct packed {
    logic [15:0]   r2;
    logic [CW-1:0] z;
    logic [CW-1:0] y;
    logic [CW-1:0] x;
  } marker_t;

  typedef struct packed {
    logic          ok;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    logic [IW-1:0] idx;
  } nbr_t;

  typedef enum logic [4:0] {
    S_WIPE, S_IDLE, S_RD0, S_RD1, S_RD2, S_RUN0, S_RUN1, S_CLR,
    S_SCAN, S_SCAN_CHK, S_SEED_RD, S_SEED_M, S_SEED_C, S_SEED_I, S_SEED_WR,
    S_NB_CALC, S_NB_IDX, S_NB_RD, S_NB_CHK, S_NB_ENQ, S_NB_NEXT,
    S_LEV, S_HEAD, S_NODE, S_NODE_LAB, S_NODE_MK, S_TAIL, S_TAIL_CHK, S_OUT
  } state_t;

  function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
    logic [DW-1:0] r;
    r = v;
    if (v == '0) r = DW'(1);
    else if (v > DW'(MAX_SIDE)) r = DW'(MAX_SIDE);
    return r;
  endfunction

  function automatic logic [5:0] off_inc(input logic [5:0] o);
    logic [5:0] r;
    r = o;
    if (o[1:0] != OFF_TOP) r[1:0] = o[1:0] + 2'd1;
    else begin
      r[1:0] = 2'd0;
      if (o[3:2] != OFF_TOP) r[3:2] = o[3:2] + 2'd1;
      else begin
        r[3:2] = 2'd0;
        r[5:4] = o[5:4] + 2'd1;
      end
    end
    return r;
  endfunction

endpackage

>>> sv/mwf_nbr.sv
module mwf_nbr (
  input  logic                        clk,
  input  logic [mwf_pkg::CW-1:0]      cx,
  input  logic [mwf_pkg::CW-1:0]      cy,
  input  logic [mwf_pkg::CW-1:0]      cz,
  input  logic [1:0]                  ox,
  input  logic [1:0]                  oy,
  input  logic [1:0]                  oz,
  input  mwf_pkg::marker_t            mk,
  input  logic [mwf_pkg::DW-1:0]      dim_x,
  input  logic [mwf_pkg::DW-1:0]      dim_y,
  input  logic [mwf_pkg::DW-1:0]      dim_z,
  output mwf_pkg::nbr_t               nb
);

  logic signed [6:0] nx, ny, nz, ex, ey, ez;
  logic [13:0] d2;
  logic inb, ok1;
  logic [mwf_pkg::CW-1:0] x1, y1, z1;
  logic [9:0] t1;
  logic [10:0] t;
  logic [15:0] n;

  always_comb begin
    nx = $signed({2'b0, cx}) + $signed({5'b0, ox}) - 7'sd1;
    ny = $signed({2'b0, cy}) + $signed({5'b0, oy}) - 7'sd1;
    nz = $signed({2'b0, cz}) + $signed({5'b0, oz}) - 7'sd1;
    ex = nx - $signed({2'b0, mk.x});
    ey = ny - $signed({2'b0, mk.y});
    ez = nz - $signed({2'b0, mk.z});
    d2 = 14'(ex * ex) + 14'(ey * ey) + 14'(ez * ez);
    inb = (nx >= 7'sd0) && (nx < $signed({1'b0, dim_x})) &&
          (ny >= 7'sd0) && (ny < $signed({1'b0, dim_y})) &&
          (nz >= 7'sd0) && (nz < $signed({1'b0, dim_z}));
    t = 11'(nz[4:0] * dim_y) + {6'b0, ny[4:0]};
    n = 16'(t1 * dim_x) + {11'b0, x1};
  end

  always_ff @(posedge clk) begin
    ok1 <= inb && ({2'b0, d2} <= mk.r2);
    x1  <= nx[4:0];
    y1  <= ny[4:0];
    z1  <= nz[4:0];
    t1  <= t[9:0];
    nb.ok  <= ok1;
    nb.x   <= x1;
    nb.y   <= y1;
    nb.z   <= z1;
    nb.idx <= n[14:0];
  end

endmodule

>>> sv/marker_watershed_flood_3d.sv
// load, add and config complete when taken; a read passes S_RD0, S_RD1, S_RD2 and S_OUT before its word
// a run clears the labels, scans the markers, seeds each in-range marker and expands every queued
// voxel over its 26 neighbours, level by level over the 256 gradient levels
// one item at a time: ready only while idle
// after reset a clearing pass sets every label unvisited, ready stays low until it ends
module marker_watershed_flood_3d #(
  parameter int MAX_MARKERS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // voxel_index, gradient, marker_x, marker_y, marker_z, radius_squared
  input  logic [1:0]  s_tuser,  // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // segmented, status, zero fill
  output logic        m_tuser,  // done_res
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  localparam int LW   = $clog2(MAX_MARKERS + 2);
  localparam int CNTW = $clog2(MAX_MARKERS + 1);
  localparam int MIW  = (MAX_MARKERS > 1) ? $clog2(MAX_MARKERS) : 1;
  localparam logic [LW-1:0] UNV = '1;
  localparam int IW = mwf_pkg::IW;
  localparam int VOL = mwf_pkg::VOL;

  mwf_pkg::state_t state, state_next;

  logic [5:0] xs, ys, zs;
  logic [5:0] dxm, dym, dzm;
  logic [10:0] xy;
  logic [15:0] total;
  logic [15:0] clr;
  logic [IW-1:0] idx_r;

  logic [1:0] act;
  logic [IW-1:0] in_idx;
  logic [7:0] in_grad;
  logic [10:0] in_mx, in_my, in_mz;
  logic [15:0] in_r2;
  logic acc, add_inb;

  mwf_pkg::marker_t mk_mem [MAX_MARKERS];
  mwf_pkg::marker_t run_mem [MAX_MARKERS];
  mwf_pkg::marker_t mk_rd, run_rd, mk, mk_wdata;
  logic mk_we, run_we;
  logic [MIW-1:0] run_raddr;
  logic [CNTW-1:0] mcount, rv, si, kk;
  logic ovf;

  logic [LW-1:0] label_mem [VOL];
  logic [LW-1:0] q_mem [VOL];
  logic [7:0]    g_mem [VOL];
  logic [IW-1:0] n_mem [VOL];
  logic [IW-1:0] c_mem [VOL];
  logic [IW-1:0] head_mem [mwf_pkg::LEVELS];
  logic [IW-1:0] tail_mem [mwf_pkg::LEVELS];
  logic [mwf_pkg::LEVELS-1:0] busy;

  logic lb_we, q_we, c_we, n_we, h_we, t_we;
  logic [IW-1:0] lb_waddr, lb_raddr, n_waddr;
  logic [LW-1:0] lb_wdata, lb_rd, q_rd, lab_m1;
  logic [7:0] g_rd, t_raddr;
  logic [IW-1:0] c_rd, n_rd, head_rd, tail_rd;

  logic [mwf_pkg::CW-1:0] cx, cy, cz;
  logic [1:0] ox, oy, oz;
  logic [5:0] off_a, off_b;
  logic off_end;
  logic [LW-1:0] lab;
  logic flood;
  logic [7:0] lev, lev_e;
  logic [IW-1:0] cur;
  mwf_pkg::nbr_t nb;

  logic res_seg, res_done, mk_inb, lab_ok;
  logic [1:0] res_st;
  logic out_load;

  assign act     = s_tuser;
  assign in_idx  = s_tdata[14:0];
  assign in_grad = s_tdata[22:15];
  assign in_mx   = s_tdata[33:23];
  assign in_my   = s_tdata[44:34];
  assign in_mz   = s_tdata[55:45];
  assign in_r2   = s_tdata[71:56];

  assign dxm = mwf_pkg::clamp_dim(xs);
  assign dym = mwf_pkg::clamp_dim(ys);
  assign dzm = mwf_pkg::clamp_dim(zs);

  assign s_tready = (state == mwf_pkg::S_IDLE);
  assign acc = s_tvalid && s_tready;
  assign add_inb = !in_mx[10] && (in_mx[9:0] < {4'b0, dxm}) &&
                   !in_my[10] && (in_my[9:0] < {4'b0, dym}) &&
                   !in_mz[10] && (in_mz[9:0] < {4'b0, dzm});
  assign mk_inb = ({1'b0, mk_rd.x} < dxm) && ({1'b0, mk_rd.y} < dym) &&
                  ({1'b0, mk_rd.z} < dzm);
  assign lab_ok = (q_rd != '0) && ({{(LW+1){1'b0}}, q_rd} <= {{(LW+1){1'b0}}, rv} +
                  {(2*LW+1-CNTW+CNTW){1'b0}});
  assign lab_m1 = q_rd - LW'(1);
  assign off_a = mwf_pkg::off_inc({oz, oy, ox});
  assign off_b = (off_a == {mwf_pkg::OFF_MID, mwf_pkg::OFF_MID, mwf_pkg::OFF_MID}) ?
                 mwf_pkg::off_inc(off_a) : off_a;
  assign off_end = (ox == mwf_pkg::OFF_TOP) && (oy == mwf_pkg::OFF_TOP) &&
                   (oz == mwf_pkg::OFF_TOP);
  assign mk_wdata = '{r2: in_r2, z: in_mz[4:0], y: in_my[4:0], x: in_mx[4:0]};
  assign mk_we = acc && (act == mwf_pkg::ACT_ADD) && add_inb &&
                 ({{(32-CNTW){1'b0}}, mcount} < 32'(MAX_MARKERS));
  assign out_load = (state == mwf_pkg::S_OUT) && (!m_tvalid || m_tready);

  mwf_nbr u_nbr (
    .clk(clk), .cx(cx), .cy(cy), .cz(cz), .ox(ox), .oy(oy), .oz(oz), .mk(mk),
    .dim_x(dxm), .dim_y(dym), .dim_z(dzm), .nb(nb)
  );

  // memories
  always_ff @(posedge clk) begin
    if (lb_we) label_mem[lb_waddr] <= lb_wdata;
    lb_rd <= label_mem[lb_raddr];
    if (acc && (act == mwf_pkg::ACT_LOAD)) g_mem[in_idx] <= in_grad;
    g_rd <= g_mem[nb.idx];
    if (q_we) q_mem[nb.idx] <= lab;
    q_rd <= q_mem[cur];
    if (c_we) c_mem[nb.idx] <= {nb.z, nb.y, nb.x};
    c_rd <= c_mem[cur];
    if (n_we) n_mem[n_waddr] <= nb.idx;
    n_rd <= n_mem[cur];
    if (h_we) head_mem[lev_e] <= nb.idx;
    head_rd <= head_mem[lev];
    if (t_we) tail_mem[lev_e] <= nb.idx;
    tail_rd <= tail_mem[t_raddr];
    if (mk_we) mk_mem[mcount[MIW-1:0]] <= mk_wdata;
    mk_rd <= mk_mem[si[MIW-1:0]];
    if (run_we) run_mem[rv[MIW-1:0]] <= mk_rd;
    run_rd <= run_mem[run_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= mwf_pkg::S_WIPE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    lb_we = 1'b0;
    lb_waddr = clr[IW-1:0];
    lb_wdata = UNV;
    lb_raddr = (state == mwf_pkg::S_NB_RD) ? nb.idx : idx_r;
    q_we = 1'b0;
    c_we = 1'b0;
    n_we = 1'b0;
    n_waddr = tail_rd;
    h_we = 1'b0;
    t_we = 1'b0;
    t_raddr = (state == mwf_pkg::S_NB_CHK) ? g_rd : lev;
    run_we = 1'b0;
    run_raddr = (state == mwf_pkg::S_NODE_LAB) ? lab_m1[MIW-1:0] : kk[MIW-1:0];
    unique case (state)
      mwf_pkg::S_WIPE: begin
        lb_we = 1'b1;
        if (clr == 16'(VOL - 1)) state_next = mwf_pkg::S_IDLE;
      end
      mwf_pkg::S_IDLE: begin
        if (acc && act == mwf_pkg::ACT_RUN) state_next = mwf_pkg::S_RUN0;
        else if (acc && act == mwf_pkg::ACT_READ) state_next = mwf_pkg::S_RD0;
      end
      mwf_pkg::S_RD0: state_next = mwf_pkg::S_RD1;
      mwf_pkg::S_RD1: state_next = mwf_pkg::S_RD2;
      mwf_pkg::S_RD2: state_next = mwf_pkg::S_OUT;
      mwf_pkg::S_RUN0: state_next = mwf_pkg::S_RUN1;
      mwf_pkg::S_RUN1: state_next = mwf_pkg::S_CLR;
      mwf_pkg::S_CLR: begin
        lb_we = 1'b1;
        if (clr == total - 16'd1) state_next = mwf_pkg::S_SCAN;
      end
      mwf_pkg::S_SCAN: begin
        if (si == mcount) state_next = (rv == '0) ? mwf_pkg::S_OUT : mwf_pkg::S_SEED_RD;
        else state_next = mwf_pkg::S_SCAN_CHK;
      end
      mwf_pkg::S_SCAN_CHK: begin
        run_we = mk_inb;
        state_next = mwf_pkg::S_SCAN;
      end
      mwf_pkg::S_SEED_RD: begin
        state_next = (kk == rv) ? mwf_pkg::S_LEV : mwf_pkg::S_SEED_M;
      end
      mwf_pkg::S_SEED_M: state_next = mwf_pkg::S_SEED_C;
      mwf_pkg::S_SEED_C: state_next = mwf_pkg::S_SEED_I;
      mwf_pkg::S_SEED_I: state_next = mwf_pkg::S_SEED_WR;
      mwf_pkg::S_SEED_WR: begin
        lb_we = 1'b1;
        lb_waddr = nb.idx;
        lb_wdata = lab;
        state_next = mwf_pkg::S_NB_CALC;
      end
      mwf_pkg::S_NB_CALC: state_next = mwf_pkg::S_NB_IDX;
      mwf_pkg::S_NB_IDX: state_next = mwf_pkg::S_NB_RD;
      mwf_pkg::S_NB_RD: state_next = nb.ok ? mwf_pkg::S_NB_CHK : mwf_pkg::S_NB_NEXT;
      mwf_pkg::S_NB_CHK: begin
        lb_waddr = nb.idx;
        if (lb_rd == UNV) begin
          lb_we = 1'b1;
          lb_wdata = lab;
          q_we = 1'b1;
          c_we = 1'b1;
          state_next = mwf_pkg::S_NB_ENQ;
        end else begin
          lb_we = (lb_rd != lab) && (lb_rd != '0);
          lb_wdata = '0;
          state_next = mwf_pkg::S_NB_NEXT;
        end
      end
      mwf_pkg::S_NB_ENQ: begin
        t_we = 1'b1;
        n_we = busy[lev_e];
        h_we = !busy[lev_e];
        state_next = mwf_pkg::S_NB_NEXT;
      end
      mwf_pkg::S_NB_NEXT: begin
        if (!off_end) state_next = mwf_pkg::S_NB_CALC;
        else state_next = flood ? mwf_pkg::S_TAIL : mwf_pkg::S_SEED_RD;
      end
      mwf_pkg::S_LEV: begin
        if (busy[lev]) state_next = mwf_pkg::S_HEAD;
        else if (lev == 8'hFF) state_next = mwf_pkg::S_OUT;
      end
      mwf_pkg::S_HEAD: state_next = mwf_pkg::S_NODE;
      mwf_pkg::S_NODE: state_next = mwf_pkg::S_NODE_LAB;
      mwf_pkg::S_NODE_LAB: state_next = lab_ok ? mwf_pkg::S_NODE_MK : mwf_pkg::S_TAIL;
      mwf_pkg::S_NODE_MK: state_next = mwf_pkg::S_NB_CALC;
      mwf_pkg::S_TAIL: state_next = mwf_pkg::S_TAIL_CHK;
      mwf_pkg::S_TAIL_CHK: begin
        if (cur != tail_rd) state_next = mwf_pkg::S_NODE;
        else if (lev == 8'hFF) state_next = mwf_pkg::S_OUT;
        else state_next = mwf_pkg::S_LEV;
      end
      mwf_pkg::S_OUT: if (!m_tvalid || m_tready) state_next = mwf_pkg::S_IDLE;
      default: state_next = mwf_pkg::S_IDLE;
    endcase
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      xs <= 6'd32;
      ys <= 6'd32;
      zs <= 6'd32;
      clr <= '0;
      mcount <= '0;
      ovf <= 1'b0;
      busy <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        priority case (cfg_index)
          mwf_pkg::REG_X: xs <= cfg_data;
          mwf_pkg::REG_Y: ys <= cfg_data;
          mwf_pkg::REG_Z: zs <= cfg_data;
          default: ;
        endcase
      end
      if (mk_we) mcount <= mcount + CNTW'(1);
      else if (acc && act == mwf_pkg::ACT_ADD && add_inb) ovf <= 1'b1;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        mwf_pkg::S_WIPE: clr <= clr + 16'd1;
        mwf_pkg::S_IDLE: begin
          clr <= '0;
          idx_r <= in_idx;
        end
        mwf_pkg::S_RD0, mwf_pkg::S_RUN0: xy <= 11'(dxm * dym);
        mwf_pkg::S_RD1: total <= 16'(xy * dzm);
        mwf_pkg::S_RD2: begin
          res_seg <= ({1'b0, idx_r} < total) && (lb_rd != UNV) && (lb_rd != '0);
          res_done <= 1'b0;
          res_st <= mwf_pkg::ST_OK;
        end
        mwf_pkg::S_RUN1: begin
          total <= 16'(xy * dzm);
          clr <= '0;
          si <= '0;
          rv <= '0;
          kk <= '0;
        end
        mwf_pkg::S_CLR: begin
          clr <= clr + 16'd1;
          if (clr == total - 16'd1) busy <= '0;
        end
        mwf_pkg::S_SCAN: begin
          res_seg <= 1'b0;
          res_done <= 1'b1;
          res_st <= mwf_pkg::ST_NOMARK;
        end
        mwf_pkg::S_SCAN_CHK: begin
          si <= si + CNTW'(1);
          if (mk_inb) rv <= rv + CNTW'(1);
        end
        mwf_pkg::S_SEED_RD: begin
          lev <= '0;
          flood <= 1'b0;
          res_st <= ovf ? mwf_pkg::ST_OVF : mwf_pkg::ST_OK;
        end
        mwf_pkg::S_SEED_M: begin
          mk <= run_rd;
          cx <= run_rd.x;
          cy <= run_rd.y;
          cz <= run_rd.z;
          ox <= mwf_pkg::OFF_MID;
          oy <= mwf_pkg::OFF_MID;
          oz <= mwf_pkg::OFF_MID;
          lab <= LW'(kk) + LW'(1);
        end
        mwf_pkg::S_SEED_WR: begin
          ox <= '0;
          oy <= '0;
          oz <= '0;
        end
        mwf_pkg::S_NB_CHK: lev_e <= g_rd;
        mwf_pkg::S_NB_ENQ: busy[lev_e] <= 1'b1;
        mwf_pkg::S_NB_NEXT: begin
          if (!off_end) {oz, oy, ox} <= off_b;
          else if (!flood) kk <= kk + CNTW'(1);
        end
        mwf_pkg::S_LEV: if (!busy[lev] && lev != 8'hFF) lev <= lev + 8'd1;
        mwf_pkg::S_HEAD: cur <= head_rd;
        mwf_pkg::S_NODE_LAB: lab <= q_rd;
        mwf_pkg::S_NODE_MK: begin
          mk <= run_rd;
          {cz, cy, cx} <= c_rd;
          ox <= '0;
          oy <= '0;
          oz <= '0;
          flood <= 1'b1;
        end
        mwf_pkg::S_TAIL_CHK: begin
          if (cur != tail_rd) cur <= n_rd;
          else if (lev != 8'hFF) lev <= lev + 8'd1;
        end
        mwf_pkg::S_OUT: begin
          if (out_load) begin
            m_tdata <= {5'b0, res_st, res_seg};
            m_tuser <= res_done;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> sv/mwf_chk.sv
module mwf_chk (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output word dropped while stalled");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_run_seg: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !m_tdata[0])
    else $error("run word marks a voxel");

  a_read_st: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[2:1] == mwf_pkg::ST_OK)
    else $error("read word carries a status");

  a_st: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:1] != 2'd3 && m_tdata[7:3] == 5'd0)
    else $error("bad status code or fill");

endmodule

bind marker_watershed_flood_3d mwf_chk u_mwf_chk (.*);
